### rtl/fsmf_pkg.sv
package fsmf_pkg;

	localparam int MAX_NEEDLE_DEF = 32;
	localparam int MAX_TEXT_DEF   = 65536;

	localparam logic FUNC_PATTERN = 1'b0;
	localparam logic FUNC_TEXT    = 1'b1;

	typedef struct packed {
		logic pat_append;
		logic pat_drop;
		logic txt_shift;
		logic txt_drop;
		logic job_end;
	} fsmf_cmd_t;

	typedef struct packed {
		logic pat_full;
		logic txt_full;
	} fsmf_status_t;

endpackage

### rtl/fsmf_dp.sv
module fsmf_dp #(
	parameter int MAX_NEEDLE = fsmf_pkg::MAX_NEEDLE_DEF,
	parameter int MAX_TEXT   = fsmf_pkg::MAX_TEXT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsmf_pkg::fsmf_cmd_t  cmd,
	output fsmf_pkg::fsmf_status_t status,
	input  logic [7:0]           data_byte,
	output logic                 found,
	output logic [15:0]          match_index,
	output logic                 pattern_overflow,
	output logic                 text_overflow
);
	import fsmf_pkg::*;

	localparam int TEXT_LIMIT = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;
	localparam int PW = $clog2(TEXT_LIMIT + 1);
	localparam int LW = $clog2(MAX_NEEDLE + 1);
	localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

	logic [7:0]            pat_q [MAX_NEEDLE];
	logic [LW-1:0]         len_q;
	logic [MAX_NEEDLE-1:0] cell_q;
	logic [MAX_NEEDLE-1:0] cell_nx;
	logic [PW-1:0]         pos_q;
	logic                  seen_q;
	logic [15:0]           first_q;
	logic                  pdrop_q;
	logic                  tdrop_q;
	logic                  found_q;
	logic [15:0]           index_q;
	logic                  pov_q;
	logic                  tov_q;

	logic [LW-1:0] len_m1;
	logic [IW-1:0] sel;
	logic          hit;
	logic [16:0]   start_w;
	logic          seen_nx;
	logic [15:0]   first_nx;

	// cell j: pattern[0..j] ends at the current text byte
	always_comb begin
		cell_nx[0] = (data_byte == pat_q[0]);
		for (int j = 1; j < MAX_NEEDLE; j++) begin
			cell_nx[j] = cell_q[j-1] & (data_byte == pat_q[j]);
		end
	end

	assign len_m1  = len_q - LW'(1);
	assign sel     = len_m1[IW-1:0];
	assign hit     = (len_q == '0) || cell_nx[sel];
	// empty pattern matches at index 0
	assign start_w = (len_q == '0) ? 17'd0 : 17'(pos_q) + 17'd1 - 17'(len_q);
	assign seen_nx = seen_q | (cmd.txt_shift & hit);
	assign first_nx = (cmd.txt_shift & hit & ~seen_q) ? start_w[15:0] : first_q;

	assign status.pat_full = (len_q == LW'(MAX_NEEDLE));
	assign status.txt_full = (pos_q == PW'(TEXT_LIMIT));

	always_ff @(posedge clk) begin
		if (cmd.pat_append) begin
			pat_q[len_q[IW-1:0]] <= data_byte;
		end
		if (cmd.job_end) begin
			found_q <= seen_nx;
			index_q <= first_nx;
			pov_q   <= pdrop_q;
			tov_q   <= tdrop_q | cmd.txt_drop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			cell_q  <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
			pdrop_q <= 1'b0;
			tdrop_q <= 1'b0;
		end else if (cmd.job_end) begin
			len_q   <= '0;
			cell_q  <= '0;
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
			pdrop_q <= 1'b0;
			tdrop_q <= 1'b0;
		end else begin
			if (cmd.pat_append) begin
				len_q <= len_q + LW'(1);
			end
			if (cmd.pat_drop) begin
				pdrop_q <= 1'b1;
			end
			if (cmd.txt_shift) begin
				cell_q  <= cell_nx;
				pos_q   <= pos_q + PW'(1);
				seen_q  <= seen_nx;
				first_q <= first_nx;
			end
			if (cmd.txt_drop) begin
				tdrop_q <= 1'b1;
			end
		end
	end

	assign found            = found_q;
	assign match_index      = index_q;
	assign pattern_overflow = pov_q;
	assign text_overflow    = tov_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_NEEDLE)) else $error("pattern length past capacity");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(TEXT_LIMIT)) else $error("text position past limit");
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q && !cmd.job_end |=> seen_q) else $error("match lost mid-job");
	a_job_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.job_end |=> len_q == '0 && pos_q == '0 && !seen_q && cell_q == '0)
		else $error("job state not cleared");

endmodule

### rtl/fsmf_ctrl.sv
module fsmf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic                   func,
	input  logic                   last_text,
	output logic                   res_valid,
	input  logic                   res_ready,
	input  fsmf_pkg::fsmf_status_t status,
	output fsmf_pkg::fsmf_cmd_t    cmd
);
	import fsmf_pkg::*;

	typedef enum logic {
		ST_PATTERN,
		ST_TEXT
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   acc;
	logic   is_text;

	assign item_ready = ~res_valid_q | res_ready;
	assign acc        = item_valid & item_ready;
	assign is_text    = (func == FUNC_TEXT);

	assign cmd.pat_append = acc & ~is_text & (state_q == ST_PATTERN) & ~status.pat_full;
	assign cmd.pat_drop   = acc & ~is_text & (state_q == ST_PATTERN) & status.pat_full;
	assign cmd.txt_shift  = acc & is_text & ~status.txt_full;
	assign cmd.txt_drop   = acc & is_text & status.txt_full;
	assign cmd.job_end    = acc & is_text & last_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PATTERN;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.job_end) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_PATTERN: begin
					if (acc && is_text && !last_text) begin
						state_q <= ST_TEXT;
					end
				end
				ST_TEXT: begin
					if (cmd.job_end) begin
						state_q <= ST_PATTERN;
					end
				end
				default: state_q <= ST_PATTERN;
			endcase
		end
	end

	assign res_valid = res_valid_q;

endmodule

### rtl/first_substring_match_finder_unit.sv
// channel | handshake              | payload
// item    | item_valid, item_ready | func, data_byte, last_text
// result  | res_valid, res_ready   | found, match_index, pattern_overflow, text_overflow
//
// One item per cycle unless stalled; result appears the cycle after the last text byte.
// A byte is compared against all pattern positions at once by the cell chain.
// item_ready drops only while a result waits and res_ready is low.
// Reset clears the job state; pattern bytes are undefined until loaded.
module first_substring_match_finder_unit #(
	parameter int MAX_NEEDLE = fsmf_pkg::MAX_NEEDLE_DEF,
	parameter int MAX_TEXT   = fsmf_pkg::MAX_TEXT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        func,
	input  logic [7:0]  data_byte,
	input  logic        last_text,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        found,
	output logic [15:0] match_index,
	output logic        pattern_overflow,
	output logic        text_overflow
);
	import fsmf_pkg::*;

	fsmf_cmd_t    cmd;
	fsmf_status_t status;

	fsmf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.func       (func),
		.last_text  (last_text),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.status     (status),
		.cmd        (cmd)
	);

	fsmf_dp #(
		.MAX_NEEDLE (MAX_NEEDLE),
		.MAX_TEXT   (MAX_TEXT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.data_byte        (data_byte),
		.found            (found),
		.match_index      (match_index),
		.pattern_overflow (pattern_overflow),
		.text_overflow    (text_overflow)
	);

endmodule
